// File: hw/rtl/sha_pkg.sv
// Package: SHA-256 constants, types and round functions.
`default_nettype none
package sha_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef logic [31:0] word_t;

  // Packed front-to-back item: one message byte or control.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } core_state_e;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_h(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t ror(input word_t v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sha_stream_if.sv
// Valid/ready stream interfaces for the hasher channels.
`default_nettype none
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;
  modport source(output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink(input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source(output valid, digest_word, word_index, last_word, input ready);
  modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sha_front.sv
// Front end: takes input transfers and queues the useful ones.
`default_nettype none
module sha_front
  import sha_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  sha_in_if.sink in_if,
  output item_t item_o,
  output logic  item_valid_o,
  input  wire   item_ready_i
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  item_t          mem_q [Depth];
  logic [AW-1:0]  wr_q, rd_q;
  logic [AW:0]    cnt_q;
  logic           push, pop, useful;

  // idle items (no byte, no end) are dropped here
  assign useful       = in_if.has_byte | in_if.end_of_message;
  assign in_if.ready  = (cnt_q != (AW+1)'(Depth));
  assign push         = in_if.valid & in_if.ready & useful;
  assign item_valid_o = (cnt_q != '0);
  assign pop          = item_valid_o & item_ready_i;
  assign item_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{data: in_if.data_byte, has_byte: in_if.has_byte,
                       eom: in_if.end_of_message};
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == (AW+1)'(Depth) |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> !pop) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count step");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/sha_core.sv
// Back end: block buffer, message schedule, round engine and digest output.
`default_nettype none
module sha_core
  import sha_pkg::*;
(
  input  wire     clk_i,
  input  wire     rst_ni,
  input  item_t   item_i,
  input  wire     item_valid_i,
  output logic    item_ready_o,
  sha_out_if.source out_if
);
  core_state_e state_q, state_d;

  word_t       buf_q [16];       // block buffer as 16 words, written a byte lane at a time
  word_t       w_q [16];         // schedule window, shifted on each load and round step
  word_t       h_q [8];
  word_t       a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
  logic [60:0] count_q;
  logic [5:0]  t_q;              // round / load / pad index
  logic        final_q;          // the end of the current message has been taken
  logic        second_q;         // a length-only block still follows
  logic        padded_q;         // padding of this message is already written
  logic [2:0]  oidx_q;
  logic        ovalid_q;

  logic [5:0]  used;
  logic [63:0] bits;
  logic        take, byte_fill;
  word_t       w_new, t1, t2, s0, s1, wt;
  word_t       sig0_a, sig1_e, ch, maj;

  assign used = count_q[5:0];
  assign bits = {count_q, 3'b000};
  assign take = item_valid_i & item_ready_o;
  assign byte_fill = take & item_i.has_byte & (used == 6'd63);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (byte_fill) state_d = ST_LOAD;
          else if (item_i.eom) state_d = ST_PAD;
        end
      end
      ST_PAD:   if (t_q == 6'd63) state_d = ST_LOAD;
      ST_LOAD:  if (t_q == 6'd15) state_d = ST_ROUND;
      ST_ROUND: if (t_q == 6'd63) state_d = ST_FOLD;
      ST_FOLD: begin
        // a message that ended on a full block still needs its padding block
        if (second_q || (final_q && !padded_q)) state_d = ST_PAD;
        else if (final_q) state_d = ST_EMIT;
        else state_d = ST_IDLE;
      end
      ST_EMIT:  if (ovalid_q && out_if.ready && oidx_q == 3'd7) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item_ready_o = (state_q == ST_IDLE);
  end

  // round datapath
  always_comb begin
    s0     = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
    s1     = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new  = w_q[0] + s0 + w_q[9] + s1;
    wt     = w_q[0];
    sig1_e = ror(e_q, 6) ^ ror(e_q, 11) ^ ror(e_q, 25);
    sig0_a = ror(a_q, 2) ^ ror(a_q, 13) ^ ror(a_q, 22);
    ch     = (e_q & f_q) ^ (~e_q & g_q);
    maj    = (a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q);
    t1     = hh_q + sig1_e + ch + round_k(t_q) + wt;
    t2     = sig0_a + maj;
  end

  // block buffer: byte writes and padding sweep
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && take && item_i.has_byte) begin
      buf_q[used[5:2]][{~used[1:0], 3'b000} +: 8] <= item_i.data;
    end else if (state_q == ST_PAD) begin
      if (t_q >= 6'd56 && (second_q || used < 6'd56)) begin
        buf_q[t_q[5:2]][{~t_q[1:0], 3'b000} +: 8] <= bits[{~t_q[2:0], 3'b000} +: 8];
      end else if (second_q || t_q > used) begin
        buf_q[t_q[5:2]][{~t_q[1:0], 3'b000} +: 8] <= 8'h00;
      end else if (t_q == used) begin
        buf_q[t_q[5:2]][{~t_q[1:0], 3'b000} +: 8] <= 8'h80;
      end
    end
  end

  // schedule window and working variables
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= buf_q[t_q[3:0]];
      if (t_q == 6'd0) begin
        a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
        e_q <= h_q[4]; f_q <= h_q[5]; g_q <= h_q[6]; hh_q <= h_q[7];
      end
    end else if (state_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
      hh_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
      d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      t_q      <= '0;
      count_q  <= '0;
      final_q  <= 1'b0;
      second_q <= 1'b0;
      padded_q <= 1'b0;
      oidx_q   <= '0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          t_q <= '0;
          if (take) begin
            if (item_i.has_byte) count_q <= count_q + 61'd1;
            final_q  <= item_i.eom;
            second_q <= 1'b0;
            padded_q <= 1'b0;
          end
        end
        ST_PAD: begin
          t_q <= t_q + 6'd1;
          if (t_q == 6'd63) begin
            // pad spilled past the length field: one more block after this
            if (!second_q && used >= 6'd56) begin
              second_q <= 1'b1;
            end else begin
              second_q <= 1'b0;
              padded_q <= 1'b1;
            end
          end
        end
        ST_LOAD: t_q <= (t_q == 6'd15) ? 6'd0 : t_q + 6'd1;
        ST_ROUND: t_q <= t_q + 6'd1;
        ST_FOLD: begin
          t_q <= '0;
          h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
          h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
          h_q[4] <= h_q[4] + e_q; h_q[5] <= h_q[5] + f_q;
          h_q[6] <= h_q[6] + g_q; h_q[7] <= h_q[7] + hh_q;
          if (final_q && padded_q) begin
            ovalid_q <= 1'b1;
            oidx_q   <= '0;
          end
        end
        ST_EMIT: begin
          if (ovalid_q && out_if.ready) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              ovalid_q <= 1'b0;
              count_q  <= '0;
              final_q  <= 1'b0;
              for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
            end
          end
        end
        default: t_q <= '0;
      endcase
    end
  end

  assign out_if.valid       = ovalid_q;
  assign out_if.digest_word = h_q[oidx_q];
  assign out_if.word_index  = oidx_q;
  assign out_if.last_word   = (oidx_q == 3'd7);

`ifndef NO_ASSERTIONS
  a_valid_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> state_q == ST_EMIT) else $error("result outside emit");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !item_ready_o) else $error("take while busy");
  a_rounds_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && t_q == 6'd63) |=> state_q == ST_FOLD)
    else $error("round count");
  a_emit_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && state_d == ST_IDLE) |=> count_q == '0)
    else $error("count not cleared");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/sha256_stream_hasher.sv
// Top level: SHA-256 stream hasher, front queue plus compression core.
//
// channel  dir  payload                                   transfer
// in_if    in   data_byte[7:0] has_byte end_of_message     valid & ready
// out_if   out  digest_word[31:0] word_index[2:0] last     valid & ready
//
// The core takes a byte whenever it is idle; each 64th byte starts a block
// compression of load, rounds and fold, during which no bytes are taken.
// Message end: padding sweep, load, rounds and fold, twice when the length spills;
// a message ended on a full block gets a padding block after it; then 8 words.
// Reset loads the initial hash values and clears the byte count.
// A queue of Depth entries (four by default) lets the input keep transferring while the core is busy.
`default_nettype none
module sha256_stream_hasher
  import sha_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  sha_in_if.sink     in_if,
  sha_out_if.source  out_if
);
  item_t item;
  logic  item_valid, item_ready;

  sha_front #(.Depth(Depth)) u_front (
    .clk_i, .rst_ni, .in_if,
    .item_o(item), .item_valid_o(item_valid), .item_ready_i(item_ready)
  );

  sha_core u_core (
    .clk_i, .rst_ni,
    .item_i(item), .item_valid_i(item_valid), .item_ready_o(item_ready),
    .out_if
  );
endmodule
`default_nettype wire

// File: test/tb_sha256_stream_hasher.sv
// Testbench for sha256_stream_hasher: directed and random byte streams checked against a SHA-256 predictor.
`timescale 1ns / 1ps
module tb_sha256_stream_hasher;
  import sha_pkg::*;

  typedef struct packed {
    word_t      word;
    logic [2:0] index;
    logic       last;
  } digest_beat_t;

  localparam word_t RoundConst[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam word_t StartHash[8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam int MaxGap = 11;
  localparam int HoldCycles = 500;

  logic clk_i;
  logic rst_ni;

  sha_in_if  in_if ();
  sha_out_if out_if ();

  sha256_stream_hasher dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if)
  );

  // Predictor state
  word_t        hash_words[8];
  logic [7:0]   block_bytes[64];
  logic [60:0]  msg_bytes;
  digest_beat_t pending_words[$];

  int  mismatches = 0;
  int  items_sent = 0;
  bit  gaps_on = 1'b1;
  bit  hold_out = 1'b0;

  function automatic word_t rotr(input word_t v, input int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  // One 64-round compression of the buffered block into the hash words
  task automatic compress_block();
    word_t w[16];
    word_t a, b, c, d, e, f, g, h, t1, t2, s0, s1, wt;
    for (int t = 0; t < 16; t++) begin
      w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
    end
    a = hash_words[0]; b = hash_words[1]; c = hash_words[2]; d = hash_words[3];
    e = hash_words[4]; f = hash_words[5]; g = hash_words[6]; h = hash_words[7];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        s0 = rotr(w[(t-15)%16], 7) ^ rotr(w[(t-15)%16], 18) ^ (w[(t-15)%16] >> 3);
        s1 = rotr(w[(t-2)%16], 17) ^ rotr(w[(t-2)%16], 19) ^ (w[(t-2)%16] >> 10);
        wt = w[t%16] + s0 + w[(t-7)%16] + s1;
        w[t%16] = wt;
      end
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + RoundConst[t] + wt;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
    hash_words[4] += e; hash_words[5] += f; hash_words[6] += g; hash_words[7] += h;
  endtask

  // Absorb one accepted item; on message end pad, finish and queue the digest
  task automatic absorb_item(input logic [7:0] data, input logic has_byte, input logic eom);
    int          used;
    logic [63:0] bit_len;
    digest_beat_t beat;
    if (has_byte) begin
      block_bytes[msg_bytes[5:0]] = data;
      msg_bytes = msg_bytes + 1'b1;
      if (msg_bytes[5:0] == 6'd0) compress_block();
    end
    if (!eom) return;
    used = msg_bytes[5:0];
    block_bytes[used] = 8'h80;
    for (int i = used + 1; i < 64; i++) block_bytes[i] = 8'h00;
    if (used >= 56) begin
      compress_block();
      for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    end
    bit_len = {msg_bytes, 3'b000};
    for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_len[63-8*i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      beat.word  = hash_words[i];
      beat.index = i[2:0];
      beat.last  = (i == 7);
      pending_words.push_back(beat);
    end
    hash_words = StartHash;
    msg_bytes  = '0;
  endtask

  // Clock and run limit
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("[sha256_stream_hasher] ERROR");
    $finish;
  end

  // Send one item, after a random gap while gaps are on; predict at the transfer
  task automatic send_item(input logic [7:0] data, input logic has_byte, input logic eom);
    int gap;
    gap = gaps_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.data_byte      <= data;
    in_if.has_byte       <= has_byte;
    in_if.end_of_message <= eom;
    do @(posedge clk_i); while (!in_if.ready);
    absorb_item(data, has_byte, eom);
    items_sent++;
  endtask

  // A message of random bytes, with stray idle items; ends on the last byte or on
  // a trailing item with no byte
  task automatic send_message(input int len, input bit end_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b1);              // empty message
    send_item(8'h61, 1'b1, 1'b0);              // "abc", ended on its last byte
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);              // idle item, no effect
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1);              // end with no byte
    send_item(8'haa, 1'b1, 1'b1);              // single-byte message
    send_item(8'h55, 1'b1, 1'b1);
  endtask

  // Lengths around the padding and block boundaries; a full block ended on its last byte
  task automatic test_block_edges();
    int edges[4] = '{55, 56, 63, 64};
    foreach (edges[i]) send_message(edges[i], i[0]);
  endtask

  // Receiver stalls for a long stretch while short messages keep coming
  task automatic test_backpressure();
    gaps_on  = 1'b0;
    hold_out = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_message($urandom_range(0, 3), 1'($urandom_range(0, 1)));
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_random_stream();
    int len;
    while (items_sent < 360) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0:       len = $urandom_range(0, 4);
        1:       len = $urandom_range(54, 66);
        default: len = $urandom_range(0, 40);
      endcase
      if (len > 360 - items_sent) len = 360 - items_sent;
      send_message(len, 1'($urandom_range(0, 1)));
    end
  endtask

  // Receiver: random stall before each result while gaps are on, plus the long hold on request
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_out) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_out = 1'b0;
      end
      stall = gaps_on ? $urandom_range(0, MaxGap) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // Result check against the oldest expected word
  always @(posedge clk_i) begin
    digest_beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest word %h index %0d", out_if.digest_word,
                   out_if.word_index);
      end else begin
        want = pending_words.pop_front();
        if (out_if.digest_word !== want.word || out_if.word_index !== want.index ||
            out_if.last_word !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                     want.word, want.index, want.last, out_if.digest_word,
                     out_if.word_index, out_if.last_word);
        end
      end
    end
  end

  initial begin
    in_if.valid          = 1'b0;
    in_if.data_byte      = 8'h00;
    in_if.has_byte       = 1'b0;
    in_if.end_of_message = 1'b0;
    hash_words = StartHash;
    msg_bytes  = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_block_edges();
    test_backpressure();
    test_random_stream();
    in_if.valid <= 1'b0;

    wait (pending_words.size() == 0);
    repeat (400) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[sha256_stream_hasher] OK");
    end else begin
      $display("[sha256_stream_hasher] ERROR");
    end
    $finish;
  end

endmodule

// File: sha256_stream_hasher.f
hw/rtl/sha_pkg.sv
hw/rtl/sha_stream_if.sv
hw/rtl/sha_front.sv
hw/rtl/sha_core.sv
hw/rtl/sha256_stream_hasher.sv
test/tb_sha256_stream_hasher.sv
